// ===== rtl/ook_pulse_width_capture_macros.svh =====
// assertion macros used by the ook pulse width capture core
`ifndef OOK_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define OOK_PULSE_WIDTH_CAPTURE_MACROS_SVH

// same-cycle implication, disabled during reset
`define OPWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OPWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/opwc_pkg.sv =====
// types and constants of the ook pulse width capture block
`timescale 1ns / 1ps

package opwc_pkg;

    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PULSES = 1'b1;

    localparam logic [7:0] TIMEOUT_MS_RESET = 8'd7;
    localparam logic [8:0] MIN_PULSES_RESET = 9'd20;

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LISTEN,
        MODE_RECV,
        MODE_PROC
    } opwc_mode_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] counter_value;
        logic        pin_high;
    } opwc_item_t;

    typedef struct packed {
        logic        pulse_valid;
        logic [15:0] pulse_width;
        logic [7:0]  pulse_index;
        logic        frame_done;
        logic [8:0]  pulse_total;
        logic        long_enough;
        logic        overflow;
    } opwc_result_t;

endpackage

// ===== rtl/opwc_in_stage.sv =====
// input register holding one accepted item
`timescale 1ns / 1ps

module opwc_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  opwc_pkg::opwc_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output opwc_pkg::opwc_item_t item
);
    import opwc_pkg::*;

    logic       valid_reg;
    opwc_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/opwc_core.sv =====
// capture state, configuration registers and per-item update logic
`timescale 1ns / 1ps
`include "ook_pulse_width_capture_macros.svh"

module opwc_core #(
    parameter int MAX_PULSES = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [opwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [opwc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               advance,
    input  opwc_pkg::opwc_item_t               item,
    output opwc_pkg::opwc_result_t             result
);
    import opwc_pkg::*;

    localparam int CW = $clog2(MAX_PULSES + 1);
    localparam int TW = (CW > 9) ? CW : 9;

    logic [7:0]  timeout_reg;
    logic [8:0]  min_pulses_reg;

    opwc_mode_t  mode_reg, mode_next;
    logic [15:0] prev_reg, prev_next;
    logic        frame_open_reg, frame_open_next;
    logic [CW-1:0] count_reg, count_next;
    logic        capture_reg, capture_next;
    logic [31:0] ms_clock_reg, ms_clock_next;
    logic [31:0] deadline_reg, deadline_next;
    logic        dl_set_reg, dl_set_next;

    logic        first;
    logic        pulse_valid;
    logic [15:0] pulse_width;
    logic        frame_done;
    logic [TW-1:0] count_cur_ext;
    logic [TW-1:0] count_new_ext;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_MS_RESET;
            min_pulses_reg <= MIN_PULSES_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_TIMEOUT_MS) begin
                timeout_reg <= cfg_wdata[7:0];
            end
            if (cfg_index == CFG_MIN_PULSES) begin
                min_pulses_reg <= cfg_wdata[8:0];
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            prev_reg       <= '0;
            frame_open_reg <= 1'b0;
            count_reg      <= '0;
            capture_reg    <= 1'b0;
            ms_clock_reg   <= '0;
            deadline_reg   <= '0;
            dl_set_reg     <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            prev_reg       <= prev_next;
            frame_open_reg <= frame_open_next;
            count_reg      <= count_next;
            capture_reg    <= capture_next;
            ms_clock_reg   <= ms_clock_next;
            deadline_reg   <= deadline_next;
            dl_set_reg     <= dl_set_next;
        end
    end

    always_comb begin
        mode_next       = mode_reg;
        prev_next       = prev_reg;
        frame_open_next = frame_open_reg;
        count_next      = count_reg;
        capture_next    = capture_reg;
        ms_clock_next   = ms_clock_reg;
        deadline_next   = deadline_reg;
        dl_set_next     = dl_set_reg;
        first           = 1'b0;
        pulse_valid     = 1'b0;
        pulse_width     = '0;
        frame_done      = 1'b0;
        if (advance) begin
            case (item.op)
                OP_ARM: begin
                    count_next      = '0;
                    frame_open_next = 1'b0;
                    mode_next       = MODE_LISTEN;
                    capture_next    = 1'b1;
                end
                OP_EDGE: begin
                    if (capture_reg && (mode_reg == MODE_LISTEN || mode_reg == MODE_RECV)) begin
                        mode_next = MODE_RECV;
                        first     = !frame_open_reg;
                        if (item.pin_high) begin
                            if (first) begin
                                frame_open_next = 1'b1;
                            end
                        end else begin
                            deadline_next = ms_clock_reg + 32'(timeout_reg);
                            dl_set_next   = 1'b1;
                        end
                        if (!first) begin
                            if (count_reg >= CW'(MAX_PULSES)) begin
                                capture_next = 1'b0;
                            end else begin
                                pulse_valid = 1'b1;
                                pulse_width = item.counter_value - prev_reg;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        prev_next = item.counter_value;
                    end
                end
                OP_TICK: begin
                    ms_clock_next = ms_clock_reg + 32'd1;
                    if (dl_set_reg && (ms_clock_next >= deadline_reg)
                            && mode_reg == MODE_RECV) begin
                        dl_set_next  = 1'b0;
                        capture_next = 1'b0;
                        mode_next    = MODE_PROC;
                        frame_done   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign count_cur_ext = TW'(count_reg);
    assign count_new_ext = TW'(count_next);

    always_comb begin
        result.pulse_valid = pulse_valid;
        result.pulse_width = pulse_width;
        result.pulse_index = pulse_valid ? count_cur_ext[7:0] : 8'd0;
        result.frame_done  = frame_done;
        result.pulse_total = count_new_ext[8:0];
        result.long_enough = count_new_ext > TW'(min_pulses_reg);
        result.overflow    = (count_next >= CW'(MAX_PULSES)) && !capture_next;
    end

    `OPWC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_PULSES),
        "pulse count beyond store size")
    `OPWC_ASSERT_NOW(a_pulse_or_done, advance && pulse_valid, !frame_done,
        "pulse and frame end on the same item")
    `OPWC_ASSERT_NEXT(a_arm_listens, advance && item.op == OP_ARM,
        mode_reg == MODE_LISTEN && capture_reg && count_reg == '0,
        "arm did not restart listening")
    `OPWC_ASSERT_NEXT(a_done_proc, advance && frame_done,
        mode_reg == MODE_PROC && !capture_reg && !dl_set_reg,
        "frame end did not stop capture")

endmodule

// ===== rtl/opwc_out_stage.sv =====
// result register toward the output channel
`timescale 1ns / 1ps

module opwc_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  opwc_pkg::opwc_result_t result,
    output logic                   ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output opwc_pkg::opwc_result_t m_result
);
    import opwc_pkg::*;

    logic         valid_reg;
    opwc_result_t result_reg;

    assign ready    = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/ook_pulse_width_capture.sv =====
// top level of the ook pulse width capture block
//
// items arrive on the s_ stream: tuser carries the op (arm, edge, millisecond
// tick), tdata the latched timer count and the pin level. every item gives
// exactly one result item on the m_ stream with the recorded pulse width,
// its index, frame end, pulse total, long-enough and overflow status.
// an item is held in the input register, is processed on its way to the
// result register and appears on m_tvalid once it is registered there.
// throughput is one item per cycle unless the receiver stalls; the 32-bit
// millisecond add and deadline compare in the update logic set the clock period.
// when the receiver stalls, the result waits in the result register while
// one more item is taken into the input register; then s_tready drops.
// synchronous reset clears both stages, returns the capture state to idle
// and loads timeout_ms = 7 and min_pulses = 20.
// configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
// no item is in flight.
`timescale 1ns / 1ps

module ook_pulse_width_capture #(
    parameter int MAX_PULSES = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [opwc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [opwc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,  // counter_value, pin_high
    input  logic [1:0]                       s_tuser,  // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pulse_width, pulse_index, pulse_total, long_enough, overflow
    output logic [39:0]                      m_tdata,
    output logic [1:0]                       m_tuser   // pulse_valid, frame_done
);
    import opwc_pkg::*;

    opwc_item_t   s_item;
    opwc_item_t   item;
    logic         item_valid;
    logic         out_ready;
    logic         advance;
    opwc_result_t result;
    opwc_result_t m_result;

    assign s_item.op            = s_tuser;
    assign s_item.counter_value = s_tdata[15:0];
    assign s_item.pin_high      = s_tdata[16];

    assign advance = item_valid && out_ready;

    opwc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    opwc_core #(
        .MAX_PULSES (MAX_PULSES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    opwc_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .ready    (out_ready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tuser = {m_result.frame_done, m_result.pulse_valid};
    assign m_tdata = {5'd0, m_result.overflow, m_result.long_enough, m_result.pulse_total,
                      m_result.pulse_index, m_result.pulse_width};

endmodule

// ===== test/tb_ook_pulse_width_capture.sv =====
// testbench for the ook pulse width capture block: directed cases, store overflow and random frames
`timescale 1ns / 1ps

module tb_ook_pulse_width_capture;
    import opwc_pkg::*;

    localparam int          STORE_DEPTH = 256;
    localparam int          STALL_LIMIT = 2000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;  // counter_value, pin_high
    logic [1:0]             s_tuser   = '0;  // op
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [39:0]            m_tdata;  // pulse_width, pulse_index, pulse_total, long_enough, overflow
    logic [1:0]             m_tuser;  // pulse_valid, frame_done

    // predictor state
    opwc_mode_t   cap_mode;
    logic [15:0]  prev_count;
    logic         frame_open;
    int unsigned  pulse_count;
    logic         capture_on;
    logic [31:0]  ms_clock;
    logic [31:0]  deadline;
    logic         deadline_set;
    logic [7:0]   timeout_ms;
    logic [8:0]   min_pulses;

    opwc_result_t pending_results[$];
    int           mismatch_count = 0;
    int           items_sent     = 0;
    int           send_idle_pct  = 0;
    int           stall_pct      = 0;
    int           quiet_cycles   = 0;

    ook_pulse_width_capture #(
        .MAX_PULSES(STORE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic opwc_result_t predict_capture(logic [1:0] op, logic [15:0] cnt,
                                                     logic pin);
        opwc_result_t r;
        logic         first;
        r = '0;
        case (op)
            OP_ARM: begin
                pulse_count = 0;
                frame_open  = 1'b0;
                cap_mode    = MODE_LISTEN;
                capture_on  = 1'b1;
            end
            OP_EDGE: begin
                if (capture_on) begin
                    if (cap_mode == MODE_LISTEN)
                        cap_mode = MODE_RECV;
                    if (cap_mode == MODE_RECV) begin
                        first = !frame_open;
                        if (pin) begin
                            if (first)
                                frame_open = 1'b1;
                        end else begin
                            deadline     = ms_clock + 32'(timeout_ms);
                            deadline_set = 1'b1;
                        end
                        if (!first) begin
                            if (pulse_count >= STORE_DEPTH) begin
                                capture_on = 1'b0;
                            end else begin
                                r.pulse_valid = 1'b1;
                                r.pulse_width = cnt - prev_count;
                                r.pulse_index = 8'(pulse_count);
                                pulse_count++;
                            end
                        end
                        prev_count = cnt;
                    end
                end
            end
            OP_TICK: begin
                ms_clock++;
                if (deadline_set && ms_clock >= deadline && cap_mode == MODE_RECV) begin
                    deadline_set = 1'b0;
                    capture_on   = 1'b0;
                    cap_mode     = MODE_PROC;
                    r.frame_done = 1'b1;
                end
            end
            default: ;
        endcase
        r.pulse_total = 9'(pulse_count);
        r.long_enough = pulse_count > min_pulses;
        r.overflow    = pulse_count >= STORE_DEPTH && !capture_on;
        return r;
    endfunction

    // expectations are taken at the accepting edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_results.push_back(predict_capture(s_tuser, s_tdata[15:0], s_tdata[16]));
    end

    task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        opwc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result item, actual %h / %h",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("pulse_valid", want.pulse_valid, m_tuser[0]);
                report_field("frame_done", want.frame_done, m_tuser[1]);
                report_field("pulse_width", want.pulse_width, m_tdata[15:0]);
                report_field("pulse_index", want.pulse_index, m_tdata[23:16]);
                report_field("pulse_total", want.pulse_total, m_tdata[32:24]);
                report_field("long_enough", want.long_enough, m_tdata[33]);
                report_field("overflow", want.overflow, m_tdata[34]);
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic [1:0] op, logic [15:0] cnt, logic pin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, pin, cnt};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        if (index == CFG_TIMEOUT_MS)
            timeout_ms = value[7:0];
        else
            min_pulses = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [8:0] timeout_val, logic [8:0] min_val);
        wait_drained();
        write_reg(CFG_TIMEOUT_MS, timeout_val);
        write_reg(CFG_MIN_PULSES, min_val);
    endtask

    task automatic test_directed_cases();
        send_item(OP_EDGE, 16'h1234, 1'b1);   // edge while idle
        send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_UNUSED, 16'hffff, 1'b1);
        send_item(OP_ARM, 16'h0000, 1'b0);
        send_item(OP_EDGE, 16'h0100, 1'b0);   // falling edge before frame opens
        send_item(OP_EDGE, 16'h0180, 1'b1);   // frame opens
        send_item(OP_EDGE, 16'hffff, 1'b0);
        send_item(OP_EDGE, 16'h0000, 1'b1);   // counter wrap
        send_item(OP_EDGE, 16'h0000, 1'b0);   // zero width
        send_item(OP_EDGE, 16'hffff, 1'b1);   // full width
        send_item(OP_ARM, 16'hffff, 1'b1);    // restart mid frame
        send_item(OP_EDGE, 16'h8000, 1'b1);
        send_item(OP_EDGE, 16'h8001, 1'b0);
        repeat (7) send_item(OP_TICK, 16'h5555, 1'b1);
        send_item(OP_EDGE, 16'haaaa, 1'b0);   // edge while processing
        send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_UNUSED, 16'h0000, 1'b0);
        send_item(OP_ARM, 16'h0000, 1'b0);
    endtask

    task automatic test_store_overflow();
        logic [15:0] cnt;
        set_config(9'd255, 9'd255);
        cnt = 16'($urandom());
        send_item(OP_ARM, 16'($urandom()), 1'($urandom()));
        send_item(OP_EDGE, cnt, 1'b1);
        for (int i = 0; i < STORE_DEPTH + 2; i++) begin
            cnt = cnt + 16'($urandom_range(0, 4000));
            send_item(OP_EDGE, cnt, 1'(i % 2));
        end
        repeat (256) send_item(OP_TICK, 16'($urandom()), 1'($urandom()));
        send_item(OP_EDGE, 16'($urandom()), 1'b0);
    endtask

    task automatic send_random_frame();
        logic [15:0] cnt;
        logic        pin;
        int          edges;
        int          ticks;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(0, 3)), 16'($urandom()), 1'($urandom()));
            return;
        end
        send_item(OP_ARM, 16'($urandom()), 1'($urandom()));
        cnt   = 16'($urandom());
        pin   = 1'($urandom());
        edges = $urandom_range(1, 12);
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_item(OP_TICK, 16'($urandom()), 1'($urandom()));
            send_item(OP_EDGE, cnt, pin);
            if ($urandom_range(0, 3) == 0)
                cnt = 16'($urandom());
            else
                cnt = cnt + 16'($urandom_range(1, 2000));
            pin = !pin;
        end
        if (timeout_ms <= 8)
            ticks = $urandom_range(0, timeout_ms + 1);
        else
            ticks = $urandom_range(0, 3);
        repeat (ticks) send_item(OP_TICK, 16'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 3) == 0)
            send_item(OP_EDGE, 16'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 19) == 0)
            wait_drained();
    endtask

    task automatic test_random_frames(int idle_pct, int stall, logic [8:0] timeout_val,
                                      logic [8:0] min_val, int count);
        int stop_at;
        set_config(timeout_val, min_val);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        stop_at       = items_sent + count;
        while (items_sent < stop_at)
            send_random_frame();
    endtask

    initial begin
        cap_mode     = MODE_IDLE;
        prev_count   = '0;
        frame_open   = 1'b0;
        pulse_count  = 0;
        capture_on   = 1'b0;
        ms_clock     = '0;
        deadline     = '0;
        deadline_set = 1'b0;
        timeout_ms   = TIMEOUT_MS_RESET;
        min_pulses   = MIN_PULSES_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_store_overflow();
        test_random_frames(0, 0, 9'd0, 9'd0, 230);
        test_random_frames(50, 0, 9'd1, 9'd511, 230);
        test_random_frames(0, 50, 9'd3, 9'd5, 230);
        test_random_frames(21, 21, 9'd7, 9'd256, 230);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/opwc_pkg.sv
rtl/opwc_in_stage.sv
rtl/opwc_core.sv
rtl/opwc_out_stage.sv
rtl/ook_pulse_width_capture.sv
test/tb_ook_pulse_width_capture.sv
